### design/cdad_pkg.sv
// Shared types, constants and calendar helper functions for the date keeper.
// Used by the controller, the datapath and the top level; depends on nothing.
package cdad_pkg;

    localparam int MAX_YEAR = 9999;

    // floor(y / 100) as (y * DIV100_MUL) >> DIV100_SHIFT, exact for 14-bit y
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;

    localparam int YEAR_W = 14;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int CNT_W  = 16;
    localparam int WDAY_W = 17;
    localparam int DN_W   = 23;
    localparam int DIFF_W = 22;
    localparam int PROD_W = 27;
    localparam int Q100_W = 8;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ADD  = 2'd1,
        OP_DIFF = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_G_DIV,
        S_G_LEAP,
        S_G_CHK,
        S_W_DIV,
        S_W_LEAP,
        S_WALK,
        S_DIFF,
        S_DONE
    } t_state;

    typedef enum logic {
        YSEL_GIVEN = 1'b0,
        YSEL_WORK  = 1'b1
    } t_ysel;

    typedef struct packed {
        logic  capture;
        logic  add_cnt;
        t_ysel ysel;
        logic  div_en;
        logic  leap_en;
        logic  dn_save;
        logic  diff_en;
        logic  walk_en;
        logic  commit_given;
        logic  commit_work;
        logic  set_invalid;
        logic  set_overflow;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic given_ok;
        logic walk_more;
        logic walk_wrap;
        logic year_last;
    } t_stat;

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // days in the months before month m of a common year
    function automatic logic [8:0] cum_days(input logic [MON_W-1:0] m);
        logic [8:0] c;
        case (m)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

endpackage

### design/calendar_date_add_and_difference.sv
// Load and difference first check the given date in the year-unit steps; an add walks the
// stored date one month at a time and redoes the year steps at each year boundary crossed;
// a no-op and an invalid given date go straight on to the done step.
// Throughput: one operation at a time; the next beat is taken in the cycle after the result
// is loaded, while that result may still wait on the output.
// Reset (i_rst_n low, synchronous): stored date becomes year 0, January 1,
// controller idles and no result is pending.
module calendar_date_add_and_difference (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_opcode,
    input  logic [cdad_pkg::YEAR_W-1:0]   i_year_in,
    input  logic [cdad_pkg::MON_W-1:0]    i_month_in,
    input  logic [cdad_pkg::DAY_W-1:0]    i_day_in,
    input  logic [cdad_pkg::CNT_W-1:0]    i_day_count,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [cdad_pkg::YEAR_W-1:0]   o_year_out,
    output logic [cdad_pkg::MON_W-1:0]    o_month_out,
    output logic [cdad_pkg::DAY_W-1:0]    o_day_out,
    output logic [cdad_pkg::DIFF_W-1:0]   o_day_difference,
    output logic [1:0]                    o_status
);

    cdad_pkg::t_cmd  w_cmd;
    cdad_pkg::t_stat w_stat;

    cdad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    cdad_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_year_in        (i_year_in),
        .i_month_in       (i_month_in),
        .i_day_in         (i_day_in),
        .i_day_count      (i_day_count),
        .o_stat           (w_stat),
        .o_year_out       (o_year_out),
        .o_month_out      (o_month_out),
        .o_day_out        (o_day_out),
        .o_day_difference (o_day_difference),
        .o_status         (o_status)
    );

endmodule

### design/cdad_ctrl.sv
// Sequencing controller for the date keeper: walks each operation through
// the datapath steps and owns the input and output handshakes. Uses cdad_pkg.
module cdad_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_opcode,
    input  logic             i_out_ready,
    input  cdad_pkg::t_stat  i_stat,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output cdad_pkg::t_cmd   o_cmd
);

    cdad_pkg::t_state r_state, n_state;
    cdad_pkg::t_op    r_op, n_op;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;
    logic             w_slot_free;

    assign w_accept    = i_in_valid && (r_state == cdad_pkg::S_IDLE);
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == cdad_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cdad_pkg::S_IDLE;
            r_op        <= cdad_pkg::OP_NOP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            cdad_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_op = cdad_pkg::t_op'(i_opcode);
                    case (cdad_pkg::t_op'(i_opcode))
                        cdad_pkg::OP_LOAD: n_state = cdad_pkg::S_G_DIV;
                        cdad_pkg::OP_DIFF: n_state = cdad_pkg::S_G_DIV;
                        cdad_pkg::OP_ADD:  n_state = cdad_pkg::S_W_DIV;
                        default:           n_state = cdad_pkg::S_DONE;
                    endcase
                end
            end
            cdad_pkg::S_G_DIV:  n_state = cdad_pkg::S_G_LEAP;
            cdad_pkg::S_G_LEAP: n_state = cdad_pkg::S_G_CHK;
            cdad_pkg::S_G_CHK: begin
                if (!i_stat.given_ok || r_op == cdad_pkg::OP_LOAD) begin
                    n_state = cdad_pkg::S_DONE;
                end else begin
                    n_state = cdad_pkg::S_W_DIV;
                end
            end
            cdad_pkg::S_W_DIV:  n_state = cdad_pkg::S_W_LEAP;
            cdad_pkg::S_W_LEAP: begin
                n_state = (r_op == cdad_pkg::OP_ADD) ? cdad_pkg::S_WALK : cdad_pkg::S_DIFF;
            end
            cdad_pkg::S_WALK: begin
                if (!i_stat.walk_more) begin
                    n_state = cdad_pkg::S_DONE;
                end else if (i_stat.walk_wrap && i_stat.year_last) begin
                    n_state = cdad_pkg::S_DONE;
                end else if (i_stat.walk_wrap) begin
                    n_state = cdad_pkg::S_W_DIV;
                end
            end
            cdad_pkg::S_DIFF: n_state = cdad_pkg::S_DONE;
            cdad_pkg::S_DONE: begin
                if (w_slot_free) begin
                    n_state = cdad_pkg::S_IDLE;
                end
            end
            default: n_state = cdad_pkg::S_IDLE;
        endcase
    end

    // commands and output beat flag
    always_comb begin
        o_cmd       = '0;
        o_cmd.ysel  = cdad_pkg::YSEL_GIVEN;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            cdad_pkg::S_IDLE: begin
                o_cmd.capture = w_accept;
                o_cmd.add_cnt = (cdad_pkg::t_op'(i_opcode) == cdad_pkg::OP_ADD);
            end
            cdad_pkg::S_G_DIV:  o_cmd.div_en  = 1'b1;
            cdad_pkg::S_G_LEAP: o_cmd.leap_en = 1'b1;
            cdad_pkg::S_G_CHK: begin
                if (!i_stat.given_ok) begin
                    o_cmd.set_invalid = 1'b1;
                end else if (r_op == cdad_pkg::OP_LOAD) begin
                    o_cmd.commit_given = 1'b1;
                end else begin
                    o_cmd.dn_save = 1'b1;
                end
            end
            cdad_pkg::S_W_DIV: begin
                o_cmd.ysel   = cdad_pkg::YSEL_WORK;
                o_cmd.div_en = 1'b1;
            end
            cdad_pkg::S_W_LEAP: begin
                o_cmd.ysel    = cdad_pkg::YSEL_WORK;
                o_cmd.leap_en = 1'b1;
            end
            cdad_pkg::S_WALK: begin
                o_cmd.ysel = cdad_pkg::YSEL_WORK;
                if (!i_stat.walk_more) begin
                    o_cmd.commit_work = 1'b1;
                end else if (i_stat.walk_wrap && i_stat.year_last) begin
                    o_cmd.set_overflow = 1'b1;
                end else begin
                    o_cmd.walk_en = 1'b1;
                end
            end
            cdad_pkg::S_DIFF: begin
                o_cmd.ysel    = cdad_pkg::YSEL_WORK;
                o_cmd.diff_en = 1'b1;
            end
            cdad_pkg::S_DONE: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == cdad_pkg::S_DONE))
        else $error("result beat raised outside the done step");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdad_pkg::S_DONE && w_slot_free) |=> r_out_valid)
        else $error("done step left without loading the result");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != cdad_pkg::S_IDLE))
        else $error("accepted beat did not start an operation");
`endif

endmodule

### design/cdad_dp.sv
// Datapath for the date keeper: stored date, work date, leap-year and
// day-number arithmetic, and the result register. Uses cdad_pkg.
module cdad_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cdad_pkg::t_cmd                i_cmd,
    input  logic [cdad_pkg::YEAR_W-1:0]   i_year_in,
    input  logic [cdad_pkg::MON_W-1:0]    i_month_in,
    input  logic [cdad_pkg::DAY_W-1:0]    i_day_in,
    input  logic [cdad_pkg::CNT_W-1:0]    i_day_count,
    output cdad_pkg::t_stat               o_stat,
    output logic [cdad_pkg::YEAR_W-1:0]   o_year_out,
    output logic [cdad_pkg::MON_W-1:0]    o_month_out,
    output logic [cdad_pkg::DAY_W-1:0]    o_day_out,
    output logic [cdad_pkg::DIFF_W-1:0]   o_day_difference,
    output logic [1:0]                    o_status
);

    // stored date
    logic [cdad_pkg::YEAR_W-1:0] r_st_year;
    logic [cdad_pkg::MON_W-1:0]  r_st_month;
    logic [cdad_pkg::DAY_W-1:0]  r_st_day;

    // given date and work date
    logic [cdad_pkg::YEAR_W-1:0] r_g_year;
    logic [cdad_pkg::MON_W-1:0]  r_g_month;
    logic [cdad_pkg::DAY_W-1:0]  r_g_day;
    logic [cdad_pkg::YEAR_W-1:0] r_w_year;
    logic [cdad_pkg::MON_W-1:0]  r_w_month;
    logic [cdad_pkg::WDAY_W-1:0] r_w_day;

    // year unit
    logic [cdad_pkg::Q100_W-1:0] r_f100;
    logic [cdad_pkg::Q100_W-1:0] r_c100;
    logic                        r_leap;
    logic [cdad_pkg::DN_W-1:0]   r_y365;
    logic [cdad_pkg::DN_W-1:0]   r_dn;

    logic [cdad_pkg::DIFF_W-1:0] r_diff;
    logic [1:0]                  r_status;

    logic [cdad_pkg::YEAR_W-1:0] r_o_year;
    logic [cdad_pkg::MON_W-1:0]  r_o_month;
    logic [cdad_pkg::DAY_W-1:0]  r_o_day;
    logic [cdad_pkg::DIFF_W-1:0] r_o_diff;
    logic [1:0]                  r_o_status;

    logic [cdad_pkg::YEAR_W-1:0] w_y;
    logic [cdad_pkg::MON_W-1:0]  w_m;
    logic [cdad_pkg::WDAY_W-1:0] w_d;
    logic [cdad_pkg::PROD_W-1:0] w_prod;
    logic [cdad_pkg::YEAR_W-1:0] w_rem;
    logic                        w_has_rem;
    logic [12:0]                 w_c4;
    logic [6:0]                  w_c400;
    logic                        w_late_leap;
    logic [cdad_pkg::DN_W-1:0]   w_dn;
    logic [cdad_pkg::DN_W-1:0]   w_abs;
    logic [cdad_pkg::DAY_W-1:0]  w_ml;

    assign w_y = (i_cmd.ysel == cdad_pkg::YSEL_WORK) ? r_w_year : r_g_year;
    assign w_m = (i_cmd.ysel == cdad_pkg::YSEL_WORK) ? r_w_month : r_g_month;
    assign w_d = (i_cmd.ysel == cdad_pkg::YSEL_WORK) ? r_w_day
                                                      : cdad_pkg::WDAY_W'(r_g_day);

    assign w_prod    = cdad_pkg::PROD_W'(w_y) * cdad_pkg::PROD_W'(cdad_pkg::DIV100_MUL);
    assign w_rem     = w_y - cdad_pkg::YEAR_W'({6'd0, r_f100} * 14'd100);
    assign w_has_rem = (w_rem != '0);

    // leap days before year y: ceil(y/4) - ceil(y/100) + ceil(y/400)
    assign w_c4        = 13'((15'(w_y) + 15'd3) >> 2);
    assign w_c400      = 7'((9'(r_c100) + 9'd3) >> 2);
    assign w_late_leap = r_leap && (w_m > 4'd2);
    assign w_dn = r_y365 + cdad_pkg::DN_W'(w_c4) - cdad_pkg::DN_W'(r_c100)
                + cdad_pkg::DN_W'(w_c400) + cdad_pkg::DN_W'(cdad_pkg::cum_days(w_m))
                + cdad_pkg::DN_W'(w_late_leap) + cdad_pkg::DN_W'(w_d);
    assign w_abs = (w_dn >= r_dn) ? (w_dn - r_dn) : (r_dn - w_dn);

    assign w_ml = cdad_pkg::month_len(w_m, r_leap);

    assign o_stat.given_ok  = (r_g_year <= cdad_pkg::YEAR_W'(cdad_pkg::MAX_YEAR))
                           && (r_g_month >= 4'd1) && (r_g_month <= 4'd12)
                           && (r_g_day != '0) && (r_g_day <= w_ml);
    assign o_stat.walk_more = (r_w_day > cdad_pkg::WDAY_W'(w_ml));
    assign o_stat.walk_wrap = (r_w_month == 4'd12);
    assign o_stat.year_last = (r_w_year == cdad_pkg::YEAR_W'(cdad_pkg::MAX_YEAR));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_year  <= '0;
            r_st_month <= 4'd1;
            r_st_day   <= 5'd1;
        end else if (i_cmd.commit_given) begin
            r_st_year  <= r_g_year;
            r_st_month <= r_g_month;
            r_st_day   <= r_g_day;
        end else if (i_cmd.commit_work) begin
            r_st_year  <= r_w_year;
            r_st_month <= r_w_month;
            r_st_day   <= cdad_pkg::DAY_W'(r_w_day);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_g_year  <= i_year_in;
            r_g_month <= i_month_in;
            r_g_day   <= i_day_in;
            r_w_year  <= r_st_year;
            r_w_month <= r_st_month;
            r_w_day   <= cdad_pkg::WDAY_W'(r_st_day)
                       + (i_cmd.add_cnt ? cdad_pkg::WDAY_W'(i_day_count) : '0);
            r_diff    <= '0;
            r_status  <= cdad_pkg::ST_OK;
        end else begin
            // advance one month, rolling into the next year after December
            if (i_cmd.walk_en) begin
                r_w_day <= r_w_day - cdad_pkg::WDAY_W'(w_ml);
                if (o_stat.walk_wrap) begin
                    r_w_month <= 4'd1;
                    r_w_year  <= r_w_year + 14'd1;
                end else begin
                    r_w_month <= r_w_month + 4'd1;
                end
            end
            if (i_cmd.set_invalid) begin
                r_status <= cdad_pkg::ST_INVALID;
            end else if (i_cmd.set_overflow) begin
                r_status <= cdad_pkg::ST_OVERFLOW;
            end
            if (i_cmd.diff_en) begin
                r_diff <= w_abs[cdad_pkg::DIFF_W-1:0];
            end
        end
        if (i_cmd.div_en) begin
            r_f100 <= w_prod[cdad_pkg::DIV100_SHIFT +: cdad_pkg::Q100_W];
        end
        if (i_cmd.leap_en) begin
            r_leap <= (w_y[1:0] == 2'd0) && (w_has_rem || (r_f100[1:0] == 2'd0));
            r_c100 <= r_f100 + cdad_pkg::Q100_W'(w_has_rem);
            r_y365 <= cdad_pkg::DN_W'(w_y) * cdad_pkg::DN_W'(365);
        end
        if (i_cmd.dn_save) begin
            r_dn <= w_dn;
        end
        if (i_cmd.out_load) begin
            r_o_year   <= r_st_year;
            r_o_month  <= r_st_month;
            r_o_day    <= r_st_day;
            r_o_diff   <= r_diff;
            r_o_status <= r_status;
        end
    end

    assign o_year_out       = r_o_year;
    assign o_month_out      = r_o_month;
    assign o_day_out        = r_o_day;
    assign o_day_difference = r_o_diff;
    assign o_status         = r_o_status;

`ifndef NO_ASSERTIONS
    a_stored_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st_month >= 4'd1) && (r_st_month <= 4'd12) && (r_st_day != '0))
        else $error("stored date holds an impossible month or day");

    a_commit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit_given || i_cmd.commit_work) |-> (r_status == cdad_pkg::ST_OK))
        else $error("stored date changed on a failed operation");

    a_diff_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && r_diff != '0) |-> (r_status == cdad_pkg::ST_OK))
        else $error("nonzero difference reported with an error status");
`endif

endmodule

### test/calendar_date_add_and_difference_tb.sv
// Testbench for the Gregorian date keeper: load, add-days, day difference and no-op beats.
// Depends on cdad_pkg and calendar_date_add_and_difference; expected results come from a
// calendar predictor kept here and are checked in order against every output beat.
module calendar_date_add_and_difference_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 20_000_000;
    localparam int          RANDOM_BEATS = 1750;

    typedef struct packed {
        logic [cdad_pkg::YEAR_W-1:0] year;
        logic [cdad_pkg::MON_W-1:0]  month;
        logic [cdad_pkg::DAY_W-1:0]  day;
        logic [cdad_pkg::DIFF_W-1:0] diff;
        logic [1:0]                  status;
    } t_date_result;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [1:0]                    i_opcode;
    logic [cdad_pkg::YEAR_W-1:0]   i_year_in;
    logic [cdad_pkg::MON_W-1:0]    i_month_in;
    logic [cdad_pkg::DAY_W-1:0]    i_day_in;
    logic [cdad_pkg::CNT_W-1:0]    i_day_count;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic [cdad_pkg::YEAR_W-1:0]   o_year_out;
    logic [cdad_pkg::MON_W-1:0]    o_month_out;
    logic [cdad_pkg::DAY_W-1:0]    o_day_out;
    logic [cdad_pkg::DIFF_W-1:0]   o_day_difference;
    logic [1:0]                    o_status;

    // calendar state mirrored by the predictor
    int unsigned  cal_year;
    int unsigned  cal_month;
    int unsigned  cal_day;

    t_date_result pending_results[$];
    int unsigned  fail_count;
    int unsigned  cycle_count;
    int unsigned  stall_left;
    bit           idle_on;

    calendar_date_add_and_difference dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_year_in        (i_year_in),
        .i_month_in       (i_month_in),
        .i_day_in         (i_day_in),
        .i_day_count      (i_day_count),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_year_out       (o_year_out),
        .o_month_out      (o_month_out),
        .o_day_out        (o_day_out),
        .o_day_difference (o_day_difference),
        .o_status         (o_status)
    );

    always #10 i_clk = ~i_clk;

    function automatic bit is_leap(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
        if (m == 2) begin
            return is_leap(y) ? 29 : 28;
        end
        if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return 31;
    endfunction

    function automatic bit date_valid(int unsigned y, int unsigned m, int unsigned d);
        if (y > cdad_pkg::MAX_YEAR || m < 1 || m > 12) begin
            return 1'b0;
        end
        return d >= 1 && d <= days_in_month(y, m);
    endfunction

    // ordinal day counted from January 1 of year 0, leap days of earlier years included
    function automatic int unsigned day_index(int unsigned y, int unsigned m, int unsigned d);
        int unsigned total;
        total = y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + d;
        for (int unsigned k = 1; k < m; k++) begin
            total += days_in_month(y, k);
        end
        return total;
    endfunction

    function automatic t_date_result advance_calendar(cdad_pkg::t_op op,
                                                      logic [cdad_pkg::YEAR_W-1:0] yr,
                                                      logic [cdad_pkg::MON_W-1:0] mo,
                                                      logic [cdad_pkg::DAY_W-1:0] dy,
                                                      logic [cdad_pkg::CNT_W-1:0] cnt);
        t_date_result r;
        int unsigned  y;
        int unsigned  m;
        int unsigned  d;
        int unsigned  a;
        int unsigned  b;
        bit           wrapped;
        r.diff   = '0;
        r.status = cdad_pkg::ST_OK;
        case (op)
            cdad_pkg::OP_LOAD: begin
                if (date_valid(yr, mo, dy)) begin
                    cal_year  = yr;
                    cal_month = mo;
                    cal_day   = dy;
                end else begin
                    r.status = cdad_pkg::ST_INVALID;
                end
            end
            cdad_pkg::OP_ADD: begin
                y       = cal_year;
                m       = cal_month;
                d       = cal_day + cnt;
                wrapped = 1'b0;
                while (!wrapped && d > days_in_month(y, m)) begin
                    d -= days_in_month(y, m);
                    m++;
                    if (m > 12) begin
                        m = 1;
                        y++;
                        if (y > cdad_pkg::MAX_YEAR) begin
                            wrapped = 1'b1;
                        end
                    end
                end
                if (wrapped) begin
                    r.status = cdad_pkg::ST_OVERFLOW;
                end else begin
                    cal_year  = y;
                    cal_month = m;
                    cal_day   = d;
                end
            end
            cdad_pkg::OP_DIFF: begin
                if (date_valid(yr, mo, dy)) begin
                    a      = day_index(cal_year, cal_month, cal_day);
                    b      = day_index(yr, mo, dy);
                    r.diff = cdad_pkg::DIFF_W'((a >= b) ? a - b : b - a);
                end else begin
                    r.status = cdad_pkg::ST_INVALID;
                end
            end
            default: ;
        endcase
        r.year  = cdad_pkg::YEAR_W'(cal_year);
        r.month = cdad_pkg::MON_W'(cal_month);
        r.day   = cdad_pkg::DAY_W'(cal_day);
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned random_year();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return $urandom_range(0, cdad_pkg::MAX_YEAR);
        end
        if (r < 65) begin
            return $urandom_range(cdad_pkg::MAX_YEAR - 19, cdad_pkg::MAX_YEAR);
        end
        if (r < 75) begin
            return $urandom_range(0, 20);
        end
        if (r < 90) begin
            return $urandom_range(0, 99) * 100;
        end
        return $urandom_range(0, 2499) * 4;
    endfunction

    task automatic random_date(output logic [cdad_pkg::YEAR_W-1:0] yr,
                               output logic [cdad_pkg::MON_W-1:0] mo,
                               output logic [cdad_pkg::DAY_W-1:0] dy);
        int unsigned y;
        int unsigned m;
        y  = random_year();
        m  = $urandom_range(1, 12);
        yr = cdad_pkg::YEAR_W'(y);
        mo = cdad_pkg::MON_W'(m);
        // favor month ends, where the rollover and leap rules bite
        dy = cdad_pkg::DAY_W'(($urandom_range(0, 4) == 0) ? days_in_month(y, m)
                                                          : $urandom_range(1, days_in_month(y, m)));
    endtask

    task automatic random_junk(output logic [cdad_pkg::YEAR_W-1:0] yr,
                               output logic [cdad_pkg::MON_W-1:0] mo,
                               output logic [cdad_pkg::DAY_W-1:0] dy);
        yr = cdad_pkg::YEAR_W'($urandom_range(0, 16383));
        mo = cdad_pkg::MON_W'($urandom_range(0, 15));
        dy = cdad_pkg::DAY_W'($urandom_range(0, 31));
    endtask

    // call at a rising edge; returns at the edge that accepts the beat
    task automatic send_beat(cdad_pkg::t_op op, logic [cdad_pkg::YEAR_W-1:0] yr,
                             logic [cdad_pkg::MON_W-1:0] mo,
                             logic [cdad_pkg::DAY_W-1:0] dy,
                             logic [cdad_pkg::CNT_W-1:0] cnt);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_year_in   <= yr;
        i_month_in  <= mo;
        i_day_in    <= dy;
        i_day_count <= cnt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(advance_calendar(op, yr, mo, dy, cnt));
    endtask

    task automatic test_reset_date();
        send_beat(cdad_pkg::OP_NOP, 14'd0, 4'd0, 5'd0, 16'd0);
        send_beat(cdad_pkg::OP_DIFF, 14'd0, 4'd1, 5'd1, 16'd0);
        // widest possible difference
        send_beat(cdad_pkg::OP_DIFF, 14'd9999, 4'd12, 5'd31, 16'd0);
    endtask

    task automatic test_load();
        send_beat(cdad_pkg::OP_LOAD, 14'd2000, 4'd2, 5'd29, 16'd0);
        send_beat(cdad_pkg::OP_LOAD, 14'd1900, 4'd2, 5'd29, 16'd0);
        send_beat(cdad_pkg::OP_LOAD, 14'd0, 4'd2, 5'd29, 16'd0);
        send_beat(cdad_pkg::OP_LOAD, 14'd2023, 4'd4, 5'd31, 16'd0);
        send_beat(cdad_pkg::OP_LOAD, 14'd2023, 4'd0, 5'd0, 16'd0);
        send_beat(cdad_pkg::OP_LOAD, 14'd2023, 4'd15, 5'd1, 16'd0);
        send_beat(cdad_pkg::OP_LOAD, 14'd10000, 4'd1, 5'd1, 16'd0);
        send_beat(cdad_pkg::OP_LOAD, 14'h3fff, 4'hf, 5'h1f, 16'hffff);
        send_beat(cdad_pkg::OP_LOAD, 14'd9999, 4'd12, 5'd31, 16'd0);
    endtask

    task automatic test_add();
        send_beat(cdad_pkg::OP_ADD, 14'd0, 4'd0, 5'd0, 16'd1);
        send_beat(cdad_pkg::OP_ADD, 14'd0, 4'd0, 5'd0, 16'd0);
        send_beat(cdad_pkg::OP_LOAD, 14'd2023, 4'd12, 5'd31, 16'd0);
        send_beat(cdad_pkg::OP_ADD, 14'd0, 4'd0, 5'd0, 16'd1);
        send_beat(cdad_pkg::OP_ADD, 14'd0, 4'd0, 5'd0, 16'd59);
        send_beat(cdad_pkg::OP_ADD, 14'd0, 4'd0, 5'd0, 16'hffff);
        send_beat(cdad_pkg::OP_LOAD, 14'd9990, 4'd1, 5'd1, 16'd0);
        send_beat(cdad_pkg::OP_ADD, 14'd0, 4'd0, 5'd0, 16'hffff);
    endtask

    task automatic test_diff();
        send_beat(cdad_pkg::OP_DIFF, 14'd2024, 4'd13, 5'd1, 16'd0);
        send_beat(cdad_pkg::OP_DIFF, 14'd0, 4'd1, 5'd1, 16'd0);
    endtask

    task automatic test_nop();
        send_beat(cdad_pkg::OP_NOP, 14'h3fff, 4'hf, 5'h1f, 16'hffff);
    endtask

    task automatic test_random();
        logic [cdad_pkg::YEAR_W-1:0] yr;
        logic [cdad_pkg::MON_W-1:0]  mo;
        logic [cdad_pkg::DAY_W-1:0]  dy;
        logic [cdad_pkg::CNT_W-1:0]  cnt;
        int unsigned                 r;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            // alternate idling stretches with back-to-back stretches
            if (n % 150 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            random_junk(yr, mo, dy);
            cnt = cdad_pkg::CNT_W'($urandom_range(0, 65535));
            r   = $urandom_range(0, 99);
            if (r < 28) begin
                if ($urandom_range(0, 4) != 0) begin
                    random_date(yr, mo, dy);
                end
                send_beat(cdad_pkg::OP_LOAD, yr, mo, dy, cnt);
            end else if (r < 63) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    cnt = cdad_pkg::CNT_W'($urandom_range(0, 40));
                end else if (r < 85) begin
                    cnt = cdad_pkg::CNT_W'($urandom_range(41, 2000));
                end else if (r < 95) begin
                    cnt = cdad_pkg::CNT_W'($urandom_range(2001, 20000));
                end
                send_beat(cdad_pkg::OP_ADD, yr, mo, dy, cnt);
            end else if (r < 93) begin
                if ($urandom_range(0, 6) != 0) begin
                    random_date(yr, mo, dy);
                end
                send_beat(cdad_pkg::OP_DIFF, yr, mo, dy, cnt);
            end else begin
                send_beat(cdad_pkg::OP_NOP, yr, mo, dy, cnt);
            end
        end
    endtask

    // output side: random back-pressure
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            i_out_ready <= (stall_left == 0);
        end
    end

    always @(posedge i_clk) begin
        t_date_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no operation pending");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_year_out !== want.year) begin
                    $error("year_out: expected %0d, got %0d", want.year, o_year_out);
                    fail_count++;
                end
                if (o_month_out !== want.month) begin
                    $error("month_out: expected %0d, got %0d", want.month, o_month_out);
                    fail_count++;
                end
                if (o_day_out !== want.day) begin
                    $error("day_out: expected %0d, got %0d", want.day, o_day_out);
                    fail_count++;
                end
                if (o_day_difference !== want.diff) begin
                    $error("day_difference: expected %0d, got %0d", want.diff,
                           o_day_difference);
                    fail_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_opcode    = '0;
        i_year_in   = '0;
        i_month_in  = '0;
        i_day_in    = '0;
        i_day_count = '0;
        i_out_ready = 1'b0;
        fail_count  = 0;
        cycle_count = 0;
        stall_left  = 0;
        idle_on     = 1'b1;
        cal_year    = 0;
        cal_month   = 1;
        cal_day     = 1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_date();
        test_load();
        test_add();
        test_diff();
        test_nop();
        test_random();
        i_in_valid <= 1'b0;

        // drain, then allow a trailing window for any stray beat
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
